// ----- hw/rtl/trsw_pkg.sv -----
// ----------------------------------------------------------------------------
// trsw_pkg
// Shared types and constants of the transparent run strip writer.
// ----------------------------------------------------------------------------
`default_nettype none

package trsw_pkg;

   // display controller command codes
   localparam logic [7:0] CMD_COLUMN_ADDR = 8'h2A;
   localparam logic [7:0] CMD_PAGE_ADDR   = 8'h2B;
   localparam logic [7:0] CMD_MEM_WRITE   = 8'h2C;

   localparam int PIXEL_W = 16;
   localparam int COORD_W = 16;
   localparam int COUNT_W = 10;
   localparam int SIZE_W  = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [SIZE_W-1:0]  SIZE_MAX  = 11'd1024;
   localparam logic [PIXEL_W-1:0] KEY_RESET = 16'hF81F;

   // header bytes ahead of the pixel bytes of a strip
   localparam int HDR_BYTES = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ORIGIN_X     = 3'd0,
      REG_ORIGIN_Y     = 3'd1,
      REG_SPRITE_WIDTH = 3'd2,
      REG_SPRITE_HEIGHT= 3'd3,
      REG_KEY_COLOR    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic accept;   // pixel beat taken this cycle
      logic load;     // next strip byte goes into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic strip;       // pixel on the input ends a strip
      logic final_byte;  // current byte index is the last of the strip
   } dp_status_type;

endpackage : trsw_pkg

`default_nettype wire

// ----- hw/rtl/trsw_ifs.sv -----
// ----------------------------------------------------------------------------
// trsw channel interfaces
// Pixel input stream and display bus byte stream, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface trsw_pix_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_color;

   modport source (output valid, output pixel_color, input ready);
   modport sink   (input valid, input pixel_color, output ready);
   modport mon    (input valid, input pixel_color, input ready);
endinterface : trsw_pix_if

interface trsw_byte_if;
   logic       valid;
   logic       ready;
   logic       is_data;
   logic [7:0] bus_byte;
   logic       last_of_run;

   modport source (output valid, output is_data, output bus_byte, output last_of_run,
                   input ready);
   modport sink   (input valid, input is_data, input bus_byte, input last_of_run,
                   output ready);
   modport mon    (input valid, input is_data, input bus_byte, input last_of_run,
                   input ready);
endinterface : trsw_byte_if

`default_nettype wire

// ----- hw/rtl/trsw_ctrl.sv -----
// ----------------------------------------------------------------------------
// trsw_ctrl
// Sequencer: takes pixels while idle, then walks the bytes of a strip.
// ----------------------------------------------------------------------------
`default_nettype none

module trsw_ctrl
   import trsw_pkg::*;
#(
   parameter int CNT_W = 6
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output      dp_cmd_type    cmd,
   output      logic [CNT_W-1:0] byte_idx
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic             load;
   logic             accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign load      = (state_ff == ST_EMIT) && (!valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && status.strip) begin
               state_in = ST_EMIT;
               idx_in   = '0;
            end
         end
         ST_EMIT: begin
            if (load) begin
               idx_in = idx_ff + 1'b1;
               if (status.final_byte) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register holds a beat until the bus takes it
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign cmd.accept = accept;
   assign cmd.load   = load;
   assign byte_idx   = idx_ff;

endmodule : trsw_ctrl

`default_nettype wire

// ----- hw/rtl/trsw_dp.sv -----
// ----------------------------------------------------------------------------
// trsw_dp
// Datapath: registers, sprite counters, run store, strip window and byte mux.
// ----------------------------------------------------------------------------
`default_nettype none

module trsw_dp
   import trsw_pkg::*;
#(
   parameter int MAX_RUN = 24,
   parameter int CNT_W   = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic [PIXEL_W-1:0]    pixel_color,
   input  wire dp_cmd_type            cmd,
   input  wire logic [CNT_W-1:0]      byte_idx,
   output      dp_status_type         status,
   output      logic                  is_data,
   output      logic [7:0]            bus_byte,
   output      logic                  last_of_run
);

   localparam int RUN_W  = $clog2(MAX_RUN + 1);
   localparam int ADDR_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
   localparam logic [RUN_W-1:0]  RUN_FULL = RUN_W'(MAX_RUN);
   localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(MAX_RUN - 1);

   // last index of a dimension, with out-of-range sizes clamped to 1..1024
   function automatic logic [COUNT_W-1:0] last_index(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] m1;
      m1 = size - 1'b1;
      if (size == '0) begin
         last_index = '0;
      end else if (size > SIZE_MAX) begin
         last_index = '1;
      end else begin
         last_index = m1[COUNT_W-1:0];
      end
   endfunction

   logic [COORD_W-1:0] origin_x_ff, origin_y_ff;
   logic [SIZE_W-1:0]  width_ff, height_ff;
   logic [PIXEL_W-1:0] key_ff;

   logic [COUNT_W-1:0] col_ff, col_in, row_ff, row_in, start_ff, start_in;
   logic [RUN_W-1:0]   run_len_ff, run_len_in;

   logic [PIXEL_W-1:0] store_mem [MAX_RUN];
   logic [PIXEL_W-1:0] rd_ff;
   logic [ADDR_W-1:0]  pix_idx_ff, pix_idx_in;

   logic [RUN_W-1:0]   strip_len_ff;
   logic [COORD_W-1:0] x1_ff, x2_ff, y_ff;
   logic               data_ff;
   logic [7:0]         byte_ff;
   logic               last_ff;

   logic               opaque, room, row_end, strip;
   logic [RUN_W-1:0]   grown_len, strip_len;
   logic [COUNT_W-1:0] start_col;
   logic [CNT_W-1:0]   final_idx;
   logic               sel_data;
   logic [7:0]         sel_byte;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         width_ff    <= SIZE_W'(1);
         height_ff   <= SIZE_W'(1);
         key_ff      <= KEY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ORIGIN_X:      origin_x_ff <= csr_data;
            REG_ORIGIN_Y:      origin_y_ff <= csr_data;
            REG_SPRITE_WIDTH:  width_ff    <= csr_data[SIZE_W-1:0];
            REG_SPRITE_HEIGHT: height_ff   <= csr_data[SIZE_W-1:0];
            REG_KEY_COLOR:     key_ff      <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // run bookkeeping for the pixel on the input
   assign opaque    = (pixel_color != key_ff);
   assign room      = (run_len_ff < RUN_FULL);
   assign row_end   = (col_ff >= last_index(width_ff));
   assign grown_len = run_len_ff + RUN_W'(room);
   assign start_col = (run_len_ff == '0) ? col_ff : start_ff;
   assign strip     = opaque ? ((grown_len >= RUN_FULL) || row_end) : (run_len_ff != '0);
   assign strip_len = opaque ? grown_len : run_len_ff;

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      start_in   = start_ff;
      run_len_in = run_len_ff;
      if (cmd.accept) begin
         if (opaque) begin
            start_in   = start_col;
            run_len_in = grown_len;
         end
         if (strip) begin
            run_len_in = '0;
         end
         if (row_end) begin
            col_in = '0;
            row_in = (row_ff >= last_index(height_ff)) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         start_ff   <= '0;
         run_len_ff <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         start_ff   <= start_in;
         run_len_ff <= run_len_in;
      end
   end

   // strip window, captured with every accepted pixel; the pixel that closes the run sets it last
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         strip_len_ff <= strip_len;
         x1_ff <= origin_x_ff + COORD_W'(start_col);
         x2_ff <= origin_x_ff + COORD_W'(start_col) + COORD_W'(strip_len) - 1'b1;
         y_ff  <= origin_y_ff + COORD_W'(row_ff);
      end
   end

   // run store: one write port, registered read one pixel ahead of the bus
   always_comb begin
      pix_idx_in = pix_idx_ff;
      if (cmd.accept) begin
         pix_idx_in = '0;
      end else if (cmd.load && (byte_idx >= CNT_W'(HDR_BYTES)) && byte_idx[0]
                   && (pix_idx_ff != ADDR_TOP)) begin
         pix_idx_in = pix_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_idx_ff <= '0;
      end else begin
         pix_idx_ff <= pix_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && opaque && room) begin
         store_mem[run_len_ff[ADDR_W-1:0]] <= pixel_color;
      end
      rd_ff <= store_mem[pix_idx_in];
   end

   // byte of the strip at the current index
   always_comb begin
      sel_data = 1'b1;
      sel_byte = byte_idx[0] ? rd_ff[7:0] : rd_ff[15:8];
      unique case (byte_idx)
         CNT_W'(0): begin
            sel_data = 1'b0;
            sel_byte = CMD_COLUMN_ADDR;
         end
         CNT_W'(1):  sel_byte = x1_ff[15:8];
         CNT_W'(2):  sel_byte = x1_ff[7:0];
         CNT_W'(3):  sel_byte = x2_ff[15:8];
         CNT_W'(4):  sel_byte = x2_ff[7:0];
         CNT_W'(5): begin
            sel_data = 1'b0;
            sel_byte = CMD_PAGE_ADDR;
         end
         CNT_W'(6):  sel_byte = y_ff[15:8];
         CNT_W'(7):  sel_byte = y_ff[7:0];
         CNT_W'(8):  sel_byte = y_ff[15:8];
         CNT_W'(9):  sel_byte = y_ff[7:0];
         CNT_W'(10), CNT_W'(11): begin
            sel_data = 1'b0;
            sel_byte = CMD_MEM_WRITE;
         end
         default: begin
         end
      endcase
   end

   assign final_idx = CNT_W'(HDR_BYTES - 1) + CNT_W'({strip_len_ff, 1'b0});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         data_ff <= sel_data;
         byte_ff <= sel_byte;
         last_ff <= status.final_byte;
      end
   end

   assign status.strip      = strip;
   assign status.final_byte = (byte_idx == final_idx);
   assign is_data     = data_ff;
   assign bus_byte    = byte_ff;
   assign last_of_run = last_ff;

endmodule : trsw_dp

`default_nettype wire

// ----- hw/rtl/transparent_run_strip_writer.sv -----
// ----------------------------------------------------------------------------
// transparent_run_strip_writer
// Color-key sprite writer: opaque pixel runs become window-and-write byte strips.
// ----------------------------------------------------------------------------
// Pixels arrive in row order, one per beat. A pixel that closes a run (color
// key after opaque pixels, an opaque pixel in the last column of a row, or a
// full run store of MAX_RUN pixels) starts a strip of 12 + 2*N bus bytes for
// a run of N pixels; the input is held off until the last byte of the strip
// has entered the output register. The bus byte register is the only limit:
// one byte per cycle while the bus is ready. The run store is a small memory
// with a registered read port, prefetched while the header goes out. The user
// must write configuration registers only while no strip is in flight; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module transparent_run_strip_writer
   import trsw_pkg::*;
#(
   parameter int MAX_RUN = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   trsw_pix_if.sink                   req_chan,
   trsw_byte_if.source                rsp_chan
);

   localparam int CNT_W = $clog2(HDR_BYTES + 2 * MAX_RUN);

   dp_cmd_type       cmd;
   dp_status_type    status;
   logic [CNT_W-1:0] byte_idx;

   trsw_ctrl #(
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd),
      .byte_idx  (byte_idx)
   );

   trsw_dp #(
      .MAX_RUN (MAX_RUN),
      .CNT_W   (CNT_W)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .pixel_color (req_chan.pixel_color),
      .cmd         (cmd),
      .byte_idx    (byte_idx),
      .status      (status),
      .is_data     (rsp_chan.is_data),
      .bus_byte    (rsp_chan.bus_byte),
      .last_of_run (rsp_chan.last_of_run)
   );

endmodule : transparent_run_strip_writer

`default_nettype wire

// ----- hw/rtl/trsw_checker.sv -----
// ----------------------------------------------------------------------------
// trsw_checker
// Port-level checks of the strip writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module trsw_checker
   import trsw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic       rsp_is_data,
   input  wire logic [7:0] rsp_bus_byte,
   input  wire logic       rsp_last_of_run
);

   // no bus beat survives reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("bus beat valid right after reset");

   // command bytes are only the three window and write codes
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_data) |->
         (rsp_bus_byte == CMD_COLUMN_ADDR || rsp_bus_byte == CMD_PAGE_ADDR ||
          rsp_bus_byte == CMD_MEM_WRITE))
      else $error("unexpected command byte");

   // a strip always ends on a pixel data byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run) |-> rsp_is_data)
      else $error("strip ends on a command byte");

   // a stalled beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_bus_byte) && $stable(rsp_is_data) &&
          $stable(rsp_last_of_run)))
      else $error("stalled bus beat changed");

endmodule : trsw_checker

bind transparent_run_strip_writer trsw_checker u_trsw_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_is_data     (rsp_chan.is_data),
   .rsp_bus_byte    (rsp_chan.bus_byte),
   .rsp_last_of_run (rsp_chan.last_of_run)
);

`default_nettype wire
